// ===== rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helper functions of the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

   // round schedule
   localparam int DOUBLE_ROUNDS = 10;
   localparam int ROUND_COUNT   = 2 * DOUBLE_ROUNDS;
   localparam int ROUND_W       = $clog2(ROUND_COUNT);
   localparam int BLOCK_WORDS   = 16;
   localparam int WORD_AW       = 4;
   localparam int WORD_W        = 32;
   localparam int CTR_W         = 64;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 64;
   localparam int VB_W          = 3;

   // "expand 32-byte k"
   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   // quarter round rotate amounts, one per step
   localparam int ROT_0 = 16;
   localparam int ROT_1 = 12;
   localparam int ROT_2 = 8;
   localparam int ROT_3 = 7;

   // register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_KEY_0_7   = 3'd0,
      CSR_KEY_8_15  = 3'd1,
      CSR_KEY_16_23 = 3'd2,
      CSR_KEY_24_31 = 3'd3,
      CSR_NONCE     = 3'd4,
      CSR_START_CTR = 3'd5
   } csr_index_type;

   // word byte counts
   localparam logic [VB_W-1:0] VB_NONE  = 3'd0;
   localparam logic [VB_W-1:0] VB_ONE   = 3'd1;
   localparam logic [VB_W-1:0] VB_TWO   = 3'd2;
   localparam logic [VB_W-1:0] VB_THREE = 3'd3;

   typedef struct packed {
      logic [CSR_DW-1:0] key_0_7;
      logic [CSR_DW-1:0] key_8_15;
      logic [CSR_DW-1:0] key_16_23;
      logic [CSR_DW-1:0] key_24_31;
      logic [CSR_DW-1:0] nonce;
      logic [CSR_DW-1:0] start_ctr;
   } cc20_cfg_type;

   // block build request toward the round core
   typedef struct packed {
      logic             start;
      logic [CTR_W-1:0] counter;
   } cc20_start_type;

   // keystream memory write port
   typedef struct packed {
      logic               we;
      logic [WORD_AW-1:0] addr;
      logic [WORD_W-1:0]  data;
   } cc20_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_READ,
      ST_HOLD
   } cc20_state_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_FEED
   } cc20_core_state_type;

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int n);
      rotl32 = (v << n) | (v >> (WORD_W - n));
   endfunction

   // input state word of a block
   function automatic logic [WORD_W-1:0] init_word(input logic [WORD_AW-1:0] idx,
                                                   input cc20_cfg_type cfg,
                                                   input logic [CTR_W-1:0] ctr);
      logic [WORD_W-1:0] r;
      unique case (idx)
         4'd0:    r = SIGMA_0;
         4'd1:    r = SIGMA_1;
         4'd2:    r = SIGMA_2;
         4'd3:    r = SIGMA_3;
         4'd4:    r = cfg.key_0_7[31:0];
         4'd5:    r = cfg.key_0_7[63:32];
         4'd6:    r = cfg.key_8_15[31:0];
         4'd7:    r = cfg.key_8_15[63:32];
         4'd8:    r = cfg.key_16_23[31:0];
         4'd9:    r = cfg.key_16_23[63:32];
         4'd10:   r = cfg.key_24_31[31:0];
         4'd11:   r = cfg.key_24_31[63:32];
         4'd12:   r = ctr[31:0];
         4'd13:   r = ctr[63:32];
         4'd14:   r = cfg.nonce[31:0];
         default: r = cfg.nonce[63:32];
      endcase
      return r;
   endfunction

   // state word of one quarter round lane; diagonal rounds shift each row
   function automatic logic [WORD_AW-1:0] qr_index(input logic [1:0] lane,
                                                   input logic diag,
                                                   input logic [1:0] row);
      logic [1:0] col;
      col = diag ? 2'(lane + row) : lane;
      return {row, col};
   endfunction

   // keep only the valid bytes, counts above four keep all
   function automatic logic [WORD_W-1:0] byte_mask(input logic [VB_W-1:0] vb);
      logic [WORD_W-1:0] m;
      case (vb)
         VB_NONE:  m = 32'h0000_0000;
         VB_ONE:   m = 32'h0000_00ff;
         VB_TWO:   m = 32'h0000_ffff;
         VB_THREE: m = 32'h00ff_ffff;
         default:  m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/cc20_if.sv =====
// ----------------------------------------------------------------------------
// cc20 stream interfaces
// Valid/ready channels for text words in and cipher words out.
// ----------------------------------------------------------------------------
interface cc20_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] text_word;
   logic [2:0]  valid_bytes;
   logic        last_word;

   modport source (output valid, text_word, valid_bytes, last_word, input ready);
   modport sink   (input valid, text_word, valid_bytes, last_word, output ready);
endinterface

interface cc20_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic [2:0]  out_valid_bytes;
   logic        out_last;
   logic [63:0] next_counter;

   modport source (output valid, out_word, out_valid_bytes, out_last, next_counter,
                   input ready);
   modport sink   (input valid, out_word, out_valid_bytes, out_last, next_counter,
                   output ready);
endinterface

// ===== rtl/cc20_ram.sv =====
// ----------------------------------------------------------------------------
// cc20_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cc20_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cc20_core.sv =====
// ----------------------------------------------------------------------------
// cc20_core
// Block function: runs the double rounds one quarter round step per cycle
// over four lanes, then writes the feed-forward sums into keystream memory.
// ----------------------------------------------------------------------------
module cc20_core (
   input  logic                    clock,
   input  logic                    reset,
   input  cc20_pkg::cc20_cfg_type  cfg,
   input  cc20_pkg::cc20_start_type start,
   output logic                    done,
   output cc20_pkg::cc20_wr_type   wr
);

   cc20_pkg::cc20_core_state_type state_ff, state_in;

   logic [cc20_pkg::WORD_W-1:0]  w_ff [cc20_pkg::BLOCK_WORDS];
   logic [cc20_pkg::WORD_W-1:0]  w_step [cc20_pkg::BLOCK_WORDS];
   logic [cc20_pkg::WORD_W-1:0]  w_init [cc20_pkg::BLOCK_WORDS];
   logic [cc20_pkg::CTR_W-1:0]   ctr_ff;
   logic [cc20_pkg::ROUND_W-1:0] round_ff;
   logic [1:0]                   step_ff;
   logic [cc20_pkg::WORD_AW-1:0] feed_ff;

   logic [cc20_pkg::WORD_AW-1:0] x_idx [4];
   logic [cc20_pkg::WORD_AW-1:0] y_idx [4];
   logic [cc20_pkg::WORD_AW-1:0] z_idx [4];
   logic [cc20_pkg::WORD_W-1:0]  sum_w [4];
   logic [cc20_pkg::WORD_W-1:0]  mix_w [4];
   logic                         last_step;

   // input state of a new block
   always_comb begin
      for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
         w_init[i] = cc20_pkg::init_word(cc20_pkg::WORD_AW'(i), cfg, start.counter);
      end
   end

   // one quarter round step on all four lanes; lanes touch disjoint words
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         x_idx[l] = cc20_pkg::qr_index(2'(l), round_ff[0], step_ff[0] ? 2'd2 : 2'd0);
         y_idx[l] = cc20_pkg::qr_index(2'(l), round_ff[0], step_ff[0] ? 2'd3 : 2'd1);
         z_idx[l] = cc20_pkg::qr_index(2'(l), round_ff[0], step_ff[0] ? 2'd1 : 2'd3);
         sum_w[l] = w_ff[x_idx[l]] + w_ff[y_idx[l]];
         case (step_ff)
            2'd0:    mix_w[l] = cc20_pkg::rotl32(w_ff[z_idx[l]] ^ sum_w[l], cc20_pkg::ROT_0);
            2'd1:    mix_w[l] = cc20_pkg::rotl32(w_ff[z_idx[l]] ^ sum_w[l], cc20_pkg::ROT_1);
            2'd2:    mix_w[l] = cc20_pkg::rotl32(w_ff[z_idx[l]] ^ sum_w[l], cc20_pkg::ROT_2);
            default: mix_w[l] = cc20_pkg::rotl32(w_ff[z_idx[l]] ^ sum_w[l], cc20_pkg::ROT_3);
         endcase
      end
      w_step = w_ff;
      for (int l = 0; l < 4; l++) begin
         w_step[x_idx[l]] = sum_w[l];
         w_step[z_idx[l]] = mix_w[l];
      end
   end

   assign last_step = (step_ff == 2'd3) &&
                      (round_ff == cc20_pkg::ROUND_W'(cc20_pkg::ROUND_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cc20_pkg::CORE_IDLE: begin
            if (start.start) begin
               state_in = cc20_pkg::CORE_ROUND;
            end
         end
         cc20_pkg::CORE_ROUND: begin
            if (last_step) begin
               state_in = cc20_pkg::CORE_FEED;
            end
         end
         cc20_pkg::CORE_FEED: begin
            if (feed_ff == cc20_pkg::WORD_AW'(cc20_pkg::BLOCK_WORDS - 1)) begin
               state_in = cc20_pkg::CORE_IDLE;
            end
         end
         default: state_in = cc20_pkg::CORE_IDLE;
      endcase
   end

   // outputs: feed-forward add straight into the memory
   always_comb begin
      wr.we   = (state_ff == cc20_pkg::CORE_FEED);
      wr.addr = feed_ff;
      wr.data = w_ff[feed_ff] + cc20_pkg::init_word(feed_ff, cfg, ctr_ff);
      done    = (state_ff == cc20_pkg::CORE_FEED) &&
                (feed_ff == cc20_pkg::WORD_AW'(cc20_pkg::BLOCK_WORDS - 1));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cc20_pkg::CORE_IDLE;
         round_ff <= '0;
         step_ff  <= '0;
         feed_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cc20_pkg::CORE_IDLE) begin
            round_ff <= '0;
            step_ff  <= '0;
            feed_ff  <= '0;
         end else if (state_ff == cc20_pkg::CORE_ROUND) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               round_ff <= round_ff + cc20_pkg::ROUND_W'(1);
            end
         end else begin
            feed_ff <= feed_ff + cc20_pkg::WORD_AW'(1);
         end
      end
   end

   // working state
   always_ff @(posedge clock) begin
      if (state_ff == cc20_pkg::CORE_IDLE && start.start) begin
         w_ff   <= w_init;
         ctr_ff <= start.counter;
      end else if (state_ff == cc20_pkg::CORE_ROUND) begin
         w_ff <= w_step;
      end
   end

endmodule

// ===== rtl/chacha20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 stream cipher, 64-bit block counter and 64-bit nonce.
// ----------------------------------------------------------------------------
// Usage: text words enter on req_if (valid/ready), byte zero in bits 7:0 with
// a valid byte count and a last flag. Each word leaves on rsp_if XORed with
// its keystream word, unused bytes zeroed; on the last word next_counter
// carries the block counter after the message. Key, nonce and start counter
// are written through the csr_ port while no word is in flight; the counter
// is loaded from start_counter on the first word of each message.
// A word inside a keystream block is read from the keystream RAM and goes
// to the result register with no build. The first word of a block starts a
// build in the shared round core at its accepting edge: 4 * 2 * DOUBLE_ROUNDS
// quarter round steps (80), sixteen feed-forward writes into the keystream
// RAM, one RAM read and the result load, after which rsp valid rises.
// One word is in flight at a time; the next is accepted while the result
// register still waits on a stalled receiver.
// Reset clears the control and configuration state, not the keystream RAM.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
   input  logic        clock,
   input  logic        reset,
   cc20_req_if.sink    req_if,
   cc20_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   cc20_pkg::cc20_cfg_type   cfg_ff;
   cc20_pkg::cc20_state_type state_ff, state_in;
   cc20_pkg::cc20_start_type core_start;
   cc20_pkg::cc20_wr_type    ram_wr;
   logic                     core_done;

   logic                               in_msg_ff;
   logic [cc20_pkg::WORD_AW-1:0]       pos_ff;
   logic [cc20_pkg::WORD_AW-1:0]       addr_ff;
   logic [cc20_pkg::CTR_W-1:0]         cnt_ff;
   logic [cc20_pkg::WORD_W-1:0]        text_ff;
   logic [cc20_pkg::VB_W-1:0]          vb_ff;
   logic                               last_ff;

   logic                               rsp_valid_ff;
   logic [cc20_pkg::WORD_W-1:0]        out_word_ff;
   logic [cc20_pkg::VB_W-1:0]          out_vb_ff;
   logic                               out_last_ff;
   logic [cc20_pkg::CTR_W-1:0]         next_cnt_ff;

   logic                               accept;
   logic                               need_build;
   logic                               rsp_load;
   logic [cc20_pkg::WORD_AW-1:0]       pos_eff;
   logic [cc20_pkg::CTR_W-1:0]         cnt_eff;
   logic [cc20_pkg::WORD_AW-1:0]       ram_raddr;
   logic [cc20_pkg::WORD_W-1:0]        ram_rdata;

   // configuration register decode
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (cc20_pkg::csr_index_type'(csr_index))
            cc20_pkg::CSR_KEY_0_7:   cfg_ff.key_0_7   <= csr_wdata;
            cc20_pkg::CSR_KEY_8_15:  cfg_ff.key_8_15  <= csr_wdata;
            cc20_pkg::CSR_KEY_16_23: cfg_ff.key_16_23 <= csr_wdata;
            cc20_pkg::CSR_KEY_24_31: cfg_ff.key_24_31 <= csr_wdata;
            cc20_pkg::CSR_NONCE:     cfg_ff.nonce     <= csr_wdata;
            cc20_pkg::CSR_START_CTR: cfg_ff.start_ctr <= csr_wdata;
            default: ;
         endcase
      end
   end

   // message position as seen by the word being accepted
   assign accept     = req_if.valid && req_if.ready;
   assign pos_eff    = in_msg_ff ? pos_ff : '0;
   assign cnt_eff    = in_msg_ff ? cnt_ff : cfg_ff.start_ctr;
   assign need_build = (pos_eff == '0);
   assign rsp_load   = (state_ff == cc20_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_if.ready);
   assign ram_raddr  = (state_ff == cc20_pkg::ST_IDLE) ? pos_eff : addr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cc20_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = need_build ? cc20_pkg::ST_BUILD : cc20_pkg::ST_HOLD;
            end
         end
         cc20_pkg::ST_BUILD: begin
            if (core_done) begin
               state_in = cc20_pkg::ST_READ;
            end
         end
         cc20_pkg::ST_READ: state_in = cc20_pkg::ST_HOLD;
         cc20_pkg::ST_HOLD: begin
            if (rsp_load) begin
               state_in = cc20_pkg::ST_IDLE;
            end
         end
         default: state_in = cc20_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_if.ready        = (state_ff == cc20_pkg::ST_IDLE);
      core_start.start    = (state_ff == cc20_pkg::ST_IDLE) && accept && need_build;
      core_start.counter  = cnt_eff;
   end

   // message control and word capture
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cc20_pkg::ST_IDLE;
         in_msg_ff <= 1'b0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            in_msg_ff <= !req_if.last_word;
            pos_ff    <= req_if.last_word ? '0 : pos_eff + cc20_pkg::WORD_AW'(1);
            cnt_ff    <= need_build ? cnt_eff + cc20_pkg::CTR_W'(1) : cnt_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff <= pos_eff;
         text_ff <= req_if.text_word;
         vb_ff   <= req_if.valid_bytes;
         last_ff <= req_if.last_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_word_ff <= (text_ff ^ ram_rdata) & cc20_pkg::byte_mask(vb_ff);
         out_vb_ff   <= vb_ff;
         out_last_ff <= last_ff;
         next_cnt_ff <= last_ff ? cnt_ff : '0;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.out_word        = out_word_ff;
   assign rsp_if.out_valid_bytes = out_vb_ff;
   assign rsp_if.out_last        = out_last_ff;
   assign rsp_if.next_counter    = next_cnt_ff;

   // block function
   cc20_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .start (core_start),
      .done  (core_done),
      .wr    (ram_wr)
   );

   // keystream block memory
   cc20_ram #(
      .WIDTH (cc20_pkg::WORD_W),
      .DEPTH (cc20_pkg::BLOCK_WORDS)
   ) u_ks_ram (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // the round core only finishes while a word waits on it
   a_done_in_build: assert property (@(posedge clock) disable iff (reset)
      core_done |-> state_ff == cc20_pkg::ST_BUILD)
      else $error("block build finished outside build state");

   // the first word of a block always starts a build
   a_build_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && need_build) |=> state_ff == cc20_pkg::ST_BUILD)
      else $error("block boundary word did not start a build");

   // a result appears only from the hold state
   a_load_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cc20_pkg::ST_HOLD))
      else $error("result raised without a completed read");

   // next counter is only reported on the last word
   a_counter_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_last_ff) |-> next_cnt_ff == '0)
      else $error("next counter reported on a non-final word");

endmodule

// ===== test/tb_chacha20_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher
// Self-checking bench for the ChaCha20 stream cipher: drives text words with
// random gaps and back-pressure, keeps its own copy of the cipher state to
// predict every cipher word, and compares each one field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_chacha20_stream_cipher;

   localparam int IDLE_LIMIT = 4000;   // cycles with no word moving on either side
   localparam int SEG_WORDS  = 130;    // minimum random words per key/counter setting
   localparam int SEGS       = 4;      // settings per idling phase
   localparam int TAIL_WAIT  = 120;    // one block build plus margin

   // one cipher word as seen on the result channel
   typedef struct {
      logic [31:0] word;
      logic [2:0]  vb;
      logic        last;
      logic [63:0] ctr;
   } cipher_word_type;

   // keystream predictor and store of pending cipher words
   class cipher_tracker;
      logic [63:0]     key_reg [4];
      logic [63:0]     nonce_reg;
      logic [63:0]     start_reg;
      logic [63:0]     block_ctr;
      logic [31:0]     ks_block [16];
      logic [31:0]     mix [16];
      logic [3:0]      word_pos;
      bit              in_msg;
      cipher_word_type pending_words [$];
      int              errors;
      int              checked;

      function new();
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         for (int i = 0; i < 16; i++) ks_block[i] = '0;
         nonce_reg = '0;
         start_reg = '0;
         block_ctr = '0;
         word_pos  = '0;
         in_msg    = 1'b0;
         errors    = 0;
         checked   = 0;
      endfunction

      function void write_reg(cc20_pkg::csr_index_type idx, logic [63:0] v);
         case (idx)
            cc20_pkg::CSR_KEY_0_7:   key_reg[0] = v;
            cc20_pkg::CSR_KEY_8_15:  key_reg[1] = v;
            cc20_pkg::CSR_KEY_16_23: key_reg[2] = v;
            cc20_pkg::CSR_KEY_24_31: key_reg[3] = v;
            cc20_pkg::CSR_NONCE:     nonce_reg  = v;
            cc20_pkg::CSR_START_CTR: start_reg  = v;
            default: ;
         endcase
      endfunction

      function logic [31:0] rol(logic [31:0] v, int n);
         logic [63:0] t;
         t = {v, v} << n;
         return t[63:32];
      endfunction

      function void quarter(int a, int b, int c, int d);
         mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], cc20_pkg::ROT_0);
         mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], cc20_pkg::ROT_1);
         mix[a] += mix[b]; mix[d] = rol(mix[d] ^ mix[a], cc20_pkg::ROT_2);
         mix[c] += mix[d]; mix[b] = rol(mix[b] ^ mix[c], cc20_pkg::ROT_3);
      endfunction

      // new 64-byte keystream block from the current counter, then bump it
      function void build_keystream();
         logic [31:0] init [16];
         init[0] = cc20_pkg::SIGMA_0;
         init[1] = cc20_pkg::SIGMA_1;
         init[2] = cc20_pkg::SIGMA_2;
         init[3] = cc20_pkg::SIGMA_3;
         for (int i = 0; i < 4; i++) begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
         end
         init[12] = block_ctr[31:0];
         init[13] = block_ctr[63:32];
         init[14] = nonce_reg[31:0];
         init[15] = nonce_reg[63:32];
         for (int i = 0; i < 16; i++) mix[i] = init[i];
         for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) ks_block[i] = mix[i] + init[i];
         block_ctr = block_ctr + 64'd1;
      endfunction

      // accepted text word: predict its cipher word
      function void note_word(logic [31:0] text, logic [2:0] vb, logic last);
         cipher_word_type e;
         logic [2:0]      nbytes;
         logic [31:0]     mask;
         nbytes = (vb > 3'd4) ? 3'd4 : vb;
         mask   = (nbytes == 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * nbytes)) - 32'd1);
         if (!in_msg) begin
            block_ctr = start_reg;
            word_pos  = '0;
            in_msg    = 1'b1;
         end
         if (word_pos == 4'd0) build_keystream();
         e.word   = (text ^ ks_block[word_pos]) & mask;
         word_pos = word_pos + 4'd1;
         e.vb     = vb;
         e.last   = last;
         e.ctr    = last ? block_ctr : 64'd0;
         if (last) begin
            in_msg   = 1'b0;
            word_pos = '0;
         end
         pending_words.push_back(e);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // accepted cipher word: compare with the oldest prediction
      task check_word(logic [31:0] word, logic [2:0] vb, logic last,
                      logic [63:0] ctr);
         cipher_word_type e;
         if (pending_words.size() == 0) begin
            report($sformatf("cipher word %h with no text word pending", word));
            return;
         end
         e = pending_words.pop_front();
         checked++;
         if (word !== e.word)
            report($sformatf("word %0d out_word %h, want %h", checked, word, e.word));
         if (vb !== e.vb)
            report($sformatf("word %0d out_valid_bytes %0d, want %0d", checked, vb, e.vb));
         if (last !== e.last)
            report($sformatf("word %0d out_last %b, want %b", checked, last, e.last));
         if (ctr !== e.ctr)
            report($sformatf("word %0d next_counter %h, want %h", checked, ctr, e.ctr));
      endtask

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   cc20_req_if req ();
   cc20_rsp_if rsp ();

   cipher_tracker tracker;
   int src_idle;
   int snk_idle;
   int quiet_cycles;
   int words_sent;
   int msgs_sent;
   int settings_used;

   chacha20_stream_cipher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(0, 99) >= snk_idle);
   end

   // cipher word check
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         tracker.check_word(rsp.out_word, rsp.out_valid_bytes, rsp.out_last,
                            rsp.next_counter);
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one text word; entered and left at a falling edge
   task automatic send_word(logic [31:0] text, logic [2:0] vb, logic last);
      while ($urandom_range(0, 99) < src_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.text_word   <= text;
      req.valid_bytes <= vb;
      req.last_word   <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tracker.note_word(text, vb, last);
      words_sent++;
      if (last) msgs_sent++;
      @(negedge clock);
   endtask

   // wait until every cipher word is back and the block is quiet
   task automatic drain();
      req.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write all six registers back to back, starting at a falling edge
   task automatic load_config(cc20_pkg::cc20_cfg_type cfg);
      logic [63:0]             vals [6];
      cc20_pkg::csr_index_type order [6];
      vals  = '{cfg.key_0_7, cfg.key_8_15, cfg.key_16_23, cfg.key_24_31,
                cfg.nonce, cfg.start_ctr};
      order = '{cc20_pkg::CSR_KEY_0_7, cc20_pkg::CSR_KEY_8_15,
                cc20_pkg::CSR_KEY_16_23, cc20_pkg::CSR_KEY_24_31,
                cc20_pkg::CSR_NONCE, cc20_pkg::CSR_START_CTR};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         tracker.write_reg(order[i], vals[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // register value, biased toward zero, all ones and carry boundaries
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         2:       v = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 40));
         3:       v = 64'h0000_0000_ffff_ffff - 64'($urandom_range(0, 40));
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // one message of random words; noisy ones carry odd byte counts anywhere
   task automatic send_message(int len, bit noisy);
      logic [31:0] text;
      logic [2:0]  vb;
      logic        last;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         text = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
         if (noisy) vb = 3'($urandom_range(0, 7));
         else       vb = last ? 3'($urandom_range(1, 4)) : 3'd4;
         send_word(text, vb, last);
      end
   endtask

   // main sequence
   initial begin
      cc20_pkg::cc20_cfg_type cfg;
      int                     seg_words;
      int                     len;
      int                     src_tab [3];
      int                     snk_tab [3];

      tracker         = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = cc20_pkg::CSR_KEY_0_7;
      csr_wdata       = '0;
      req.valid       = 1'b0;
      req.text_word   = '0;
      req.valid_bytes = '0;
      req.last_word   = 1'b0;
      rsp.ready       = 1'b0;
      quiet_cycles    = 0;
      words_sent      = 0;
      msgs_sent       = 0;
      settings_used   = 0;
      src_tab         = '{27, 82, 0};
      snk_tab         = '{82, 27, 0};
      src_idle        = src_tab[0];
      snk_idle        = snk_tab[0];

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero key and counter: empty word, oversized count, short word mid-message
      cfg = '0;
      load_config(cfg);
      send_word(32'h0000_0000, 3'd4, 1'b0);
      send_word(32'hffff_ffff, cc20_pkg::VB_NONE, 1'b0);
      send_word(32'hffff_ffff, 3'd7, 1'b0);
      send_word(32'h1234_5678, cc20_pkg::VB_TWO, 1'b0);
      send_word(32'hffff_ffff, cc20_pkg::VB_ONE, 1'b1);
      drain();

      // all-ones key and nonce, counter wraps past 2^64 across a block boundary
      cfg = '1;
      load_config(cfg);
      for (int i = 0; i < 17; i++) begin
         send_word(i[0] ? 32'h0000_0000 : 32'hffff_ffff,
                   (i == 16) ? cc20_pkg::VB_THREE : (i == 5) ? 3'd5 : (i == 9) ? 3'd6 :
                   (i == 12) ? cc20_pkg::VB_NONE : 3'd4,
                   i == 16);
      end
      drain();

      // counter carry from the low to the high state word, one-word message
      cfg.start_ctr = 64'h0000_0000_ffff_ffff;
      load_config(cfg);
      send_word(32'h0000_0000, 3'd4, 1'b1);
      drain();

      // random messages over three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         src_idle = src_tab[ph];
         snk_idle = snk_tab[ph];
         for (int s = 0; s < SEGS; s++) begin
            cfg.key_0_7   = pick_value();
            cfg.key_8_15  = pick_value();
            cfg.key_16_23 = pick_value();
            cfg.key_24_31 = pick_value();
            cfg.nonce     = pick_value();
            cfg.start_ctr = pick_value();
            load_config(cfg);
            seg_words = 0;
            while (seg_words < SEG_WORDS) begin
               case ($urandom_range(0, 9))
                  0:       len = 16;
                  1:       len = 16 * $urandom_range(1, 3) + $urandom_range(0, 1);
                  2:       len = $urandom_range(17, 48);
                  default: len = $urandom_range(1, 15);
               endcase
               send_message(len, $urandom_range(0, 9) == 0);
               seg_words += len;
            end
            drain();
         end
      end

      // let any stray cipher word show up
      repeat (TAIL_WAIT) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d cipher words never arrived", tracker.pending()));

      $display("sent %0d text words in %0d messages over %0d key/counter settings",
               words_sent, msgs_sent, settings_used);
      $display("checked %0d cipher words, %0d mismatches", tracker.checked,
               tracker.errors);
      if (tracker.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== chacha20_stream_cipher.f =====
rtl/cc20_pkg.sv
rtl/cc20_if.sv
rtl/cc20_ram.sv
rtl/cc20_core.sv
rtl/chacha20_stream_cipher.sv
test/tb_chacha20_stream_cipher.sv
